@@ sv/sre_pkg.sv @@
// shared types and constants for the stutter / beat-repeat effect
// no dependencies
package sre_pkg;

    localparam int STORE_DEPTH_DEF = 262144;
    localparam int SAMPLE_W        = 16;
    localparam int CFG_W           = 18;
    localparam int FADE_W          = 17;
    localparam int DIR_W           = 3;
    localparam int GAIN_W          = 10;
    localparam int MIX_W           = 9;
    localparam int CNT_W           = 17;
    localparam int ENV_W           = 17;

    localparam int OPA_W  = 44;
    localparam int OPB_W  = 18;
    localparam int PROD_W = OPA_W + OPB_W;
    localparam int ACC_W  = 43;

    localparam int DIV_NW = 34;
    localparam int DIV_DW = 18;
    localparam int DIV_CW = 6;
    localparam logic [DIV_CW-1:0] DIV_STEPS_MOD = 6'd18;
    localparam logic [DIV_CW-1:0] DIV_STEPS_ENV = 6'd34;

    localparam logic [ENV_W-1:0] ENV_ONE     = 17'h10000;
    localparam logic [CNT_W-1:0] LCG_MUL_LO  = 17'h04E6D;
    localparam logic [CNT_W-1:0] LCG_ADD_LO  = 17'd12345;
    localparam int               LCG_BIT     = 16;
    localparam logic [MIX_W-1:0] MIX_FULL    = 9'd256;
    localparam logic [GAIN_W-1:0] GAIN_MAX   = 10'd512;

    typedef enum logic [2:0] {
        REG_CAPTURE_LEN   = 3'd0,
        REG_REPEAT_PERIOD = 3'd1,
        REG_WINDOW_LEN    = 3'd2,
        REG_GATE_LEN      = 3'd3,
        REG_FADE_LEN      = 3'd4,
        REG_START_OFFSET  = 3'd5,
        REG_DIRECTION     = 3'd6,
        REG_OUTPUT_GAIN   = 3'd7
    } cfg_idx_t;

    localparam logic [DIR_W-1:0] DIR_FWD   = 3'd0;
    localparam logic [DIR_W-1:0] DIR_REV   = 3'd1;
    localparam logic [DIR_W-1:0] DIR_PING  = 3'd2;
    localparam logic [DIR_W-1:0] DIR_PONG  = 3'd3;
    localparam logic [DIR_W-1:0] DIR_RAND  = 3'd4;

    typedef struct packed {
        logic              start;
        logic [DIV_CW-1:0] steps;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_NW-1:0] quot;
        logic [DIV_DW-1:0] rem;
    } div_rsp_t;

endpackage

@@ sv/stutter_repeat_effect.sv @@
// stutter / beat-repeat effect top level: capture store, sequencer, shared multiplier
// depends on sre_pkg, sre_ram, sre_div
//
// One stereo pair is taken at a time. With trigger low the pair is stored and the gained
// dry pair comes out; with trigger high a replayed pair comes out. The phase modulo
// window runs 18 steps and the envelope ramp division, when the gate envelope sits on a
// ramp, 34 steps on the one-bit-per-cycle divider, and all products go through one
// registered 44x18 multiplier. After reset the capture store is zeroed one entry per
// cycle, with s_ready low.
// Configuration writes are taken at any time but belong to idle periods.
module stutter_repeat_effect import sre_pkg::*; #(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [2:0]                 cfg_index,
    input  logic [CFG_W-1:0]           cfg_wr_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [SAMPLE_W-1:0] s_left_in,
    input  logic signed [SAMPLE_W-1:0] s_right_in,
    input  logic                       s_trigger,
    input  logic [MIX_W-1:0]           s_wet_mix,
    input  logic [MIX_W-1:0]           s_duck_amount,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [SAMPLE_W-1:0] m_left_out,
    output logic signed [SAMPLE_W-1:0] m_right_out
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int XW = ((AW > CFG_W) ? AW : CFG_W) + 2;
    localparam logic [XW-1:0] DEPTH_X = XW'(STORE_DEPTH);
    localparam logic [XW-1:0] DEPTH_M1 = XW'(STORE_DEPTH - 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_DEPTH - 1);
    localparam int SAT_HI = (1 << (SAMPLE_W - 1)) - 1;
    localparam int SAT_LO = -(1 << (SAMPLE_W - 1));

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_DRY1, ST_DRY2, ST_DRY3,
        ST_WRAP, ST_LCG, ST_LCG2, ST_DIR, ST_MOD, ST_ADDR, ST_ENV,
        ST_X1, ST_X2, ST_X3, ST_X4, ST_X5, ST_X6, ST_X7, ST_X8, ST_X9, ST_X10, ST_X11,
        ST_DONE
    } state_t;

    function automatic logic [SAMPLE_W-1:0] round_sat(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W:0]    t;
        logic signed [PROD_W-32:0] q;
        logic [SAMPLE_W-1:0]       r;
        t = $signed({p[PROD_W-1], p}) + $signed((PROD_W+1)'(33'h0_8000_0000));
        q = t[PROD_W:32];
        if (q > SAT_HI) begin
            r = SAMPLE_W'(SAT_HI);
        end else if (q < SAT_LO) begin
            r = SAMPLE_W'(SAT_LO);
        end else begin
            r = q[SAMPLE_W-1:0];
        end
        return r;
    endfunction

    state_t state_reg;

    // configuration
    logic [CFG_W-1:0]  capture_len_reg, repeat_period_reg, window_len_reg;
    logic [CFG_W-1:0]  gate_len_reg, start_offset_reg;
    logic [FADE_W-1:0] fade_len_reg;
    logic [DIR_W-1:0]  direction_mode_reg;
    logic [GAIN_W-1:0] output_gain_reg;

    // effective values, settled through a chain of registers
    logic [XW-1:0]     cap_reg, win_reg, base_reg;
    logic [CFG_W-1:0]  rate_reg, gate_reg, wl1_reg;
    logic [FADE_W-1:0] fade_reg;
    logic [DIR_W-1:0]  dir_reg;
    logic [XW-1:0]     cap_next, cap_lo;
    logic [GAIN_W-1:0] gain_eff;

    // effect state
    logic [AW-1:0]     write_pos_reg, frozen_pos_reg, clr_addr_reg;
    logic [CFG_W-1:0]  phase_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              last_trig_reg;

    // per-item working registers
    logic signed [SAMPLE_W-1:0] dl_reg, dr_reg;
    logic [MIX_W-1:0]           m_reg, d_reg;
    logic                       rev_reg, env_div_reg;
    logic [CFG_W-1:0]           wp_reg;
    logic [XW-1:0]              rd_base_reg;
    logic [ENV_W-1:0]           e_reg;
    logic [OPB_W-2:0]           md_reg;
    logic [24:0]                cw_reg, cd_reg;
    logic signed [ACC_W-1:0]    accl_reg, accr_reg;
    logic [SAMPLE_W-1:0]        res_l_reg, res_r_reg;
    logic                       m_valid_reg;
    logic [SAMPLE_W-1:0]        m_left_reg, m_right_reg;

    // shared multiplier
    logic signed [OPA_W-1:0]  op_a_reg;
    logic signed [OPB_W-1:0]  op_b_reg;
    logic signed [PROD_W-1:0] prod_reg;

    // combinational helpers
    logic                       accept;
    logic [CNT_W-1:0]           lcg_lo;
    logic                       rev_next;
    logic [XW-1:0]              off_x, idx_sum, idx_mod;
    logic [CFG_W-1:0]           rel_num, env_num;
    logic                       att_on, rel_on;
    logic [ENV_W-1:0]           e_val;
    logic [40:0]                cd_sum;
    logic [24:0]                cd_next;
    logic signed [ACC_W-1:0]    accr_sum;
    logic signed [SAMPLE_W-1:0] sl, sr;
    logic [2*SAMPLE_W-1:0]      rd_data;
    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [2*SAMPLE_W-1:0]      ram_wdata;
    div_req_t                   div_req;
    div_rsp_t                   div_rsp;

    assign accept   = s_valid && s_ready;
    assign s_ready  = state_reg == ST_IDLE;
    assign gain_eff = (output_gain_reg > GAIN_MAX) ? GAIN_MAX : output_gain_reg;

    assign cap_lo   = (capture_len_reg == '0) ? XW'(1) : XW'(capture_len_reg);
    assign cap_next = (cap_lo > DEPTH_M1) ? DEPTH_M1 : cap_lo;

    assign lcg_lo = prod_reg[CNT_W-1:0] + LCG_ADD_LO;

    always_comb begin
        unique case (dir_reg)
            DIR_FWD:           rev_next = 1'b0;
            DIR_REV:           rev_next = 1'b1;
            DIR_PING, DIR_PONG: rev_next = count_reg[0];
            default:           rev_next = lcg_lo[LCG_BIT];
        endcase
    end

    assign off_x   = rev_reg ? (win_reg - XW'(1) - XW'(wp_reg)) : XW'(wp_reg);
    assign idx_sum = rd_base_reg + off_x;
    assign idx_mod = (idx_sum >= DEPTH_X) ? (idx_sum - DEPTH_X) : idx_sum;

    assign att_on  = phase_reg < CFG_W'(fade_reg);
    assign rel_on  = phase_reg >= (gate_reg - CFG_W'(fade_reg));
    assign rel_num = gate_reg - phase_reg;
    always_comb begin
        if (att_on && rel_on) begin
            env_num = (phase_reg < rel_num) ? phase_reg : rel_num;
        end else if (att_on) begin
            env_num = phase_reg;
        end else begin
            env_num = rel_num;
        end
    end

    assign e_val    = env_div_reg ? div_rsp.quot[ENV_W-1:0] : e_reg;
    assign cd_sum   = prod_reg[40:0] + 41'h8000;
    assign cd_next  = cd_sum[40:16];
    assign accr_sum = accr_reg + ACC_W'(prod_reg);
    assign sl       = rd_data[2*SAMPLE_W-1:SAMPLE_W];
    assign sr       = rd_data[SAMPLE_W-1:0];

    always_comb begin
        div_req.start = 1'b0;
        div_req.steps = DIV_STEPS_MOD;
        div_req.num   = {phase_reg, 16'b0};
        div_req.den   = win_reg[DIV_DW-1:0];
        if (state_reg == ST_DIR) begin
            div_req.start = 1'b1;
        end else if (state_reg == ST_ADDR) begin
            div_req.start = (phase_reg < gate_reg) && (fade_reg != '0) && (att_on || rel_on);
            div_req.steps = DIV_STEPS_ENV;
            div_req.num   = {env_num, 16'b0};
            div_req.den   = DIV_DW'(fade_reg);
        end
    end

    assign ram_we    = (state_reg == ST_CLEAR) || (accept && !s_trigger);
    assign ram_waddr = (state_reg == ST_CLEAR) ? clr_addr_reg : write_pos_reg;
    assign ram_wdata = (state_reg == ST_CLEAR) ? '0 : {s_left_in, s_right_in};

    sre_ram #(
        .WIDTH (2*SAMPLE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (state_reg == ST_ADDR),
        .raddr (idx_mod[AW-1:0]),
        .rdata (rd_data)
    );

    sre_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_ff @(posedge aclk) begin
        prod_reg <= op_a_reg * op_b_reg;

        cap_reg  <= cap_next;
        rate_reg <= (repeat_period_reg == '0) ? CFG_W'(1) : repeat_period_reg;
        dir_reg  <= (direction_mode_reg > DIR_RAND) ? DIR_RAND : direction_mode_reg;
        wl1_reg  <= (window_len_reg == '0) ? CFG_W'(1) : window_len_reg;
        win_reg  <= (XW'(wl1_reg) > cap_reg) ? cap_reg : XW'(wl1_reg);
        gate_reg <= (gate_len_reg > rate_reg) ? rate_reg : gate_len_reg;
        fade_reg <= (fade_len_reg > gate_reg[CFG_W-1:1]) ? gate_reg[CFG_W-1:1] : fade_len_reg;
        base_reg <= (XW'(start_offset_reg) > (cap_reg - win_reg)) ?
                    (cap_reg - win_reg) : XW'(start_offset_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_CLEAR;
            clr_addr_reg       <= '0;
            capture_len_reg    <= CFG_W'(48000);
            repeat_period_reg  <= CFG_W'(12000);
            window_len_reg     <= CFG_W'(12000);
            gate_len_reg       <= CFG_W'(12000);
            fade_len_reg       <= '0;
            start_offset_reg   <= '0;
            direction_mode_reg <= DIR_FWD;
            output_gain_reg    <= GAIN_W'(256);
            write_pos_reg      <= '0;
            frozen_pos_reg     <= '0;
            phase_reg          <= '0;
            count_reg          <= '0;
            last_trig_reg      <= 1'b0;
            m_valid_reg        <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_CAPTURE_LEN:   capture_len_reg    <= cfg_wr_data;
                    REG_REPEAT_PERIOD: repeat_period_reg  <= cfg_wr_data;
                    REG_WINDOW_LEN:    window_len_reg     <= cfg_wr_data;
                    REG_GATE_LEN:      gate_len_reg       <= cfg_wr_data;
                    REG_FADE_LEN:      fade_len_reg       <= cfg_wr_data[FADE_W-1:0];
                    REG_START_OFFSET:  start_offset_reg   <= cfg_wr_data;
                    REG_DIRECTION:     direction_mode_reg <= cfg_wr_data[DIR_W-1:0];
                    REG_OUTPUT_GAIN:   output_gain_reg    <= cfg_wr_data[GAIN_W-1:0];
                endcase
            end

            if (m_valid_reg && m_ready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_CLEAR: begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == LAST_ADDR) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        dl_reg        <= s_left_in;
                        dr_reg        <= s_right_in;
                        m_reg         <= (s_wet_mix > MIX_FULL) ? MIX_FULL : s_wet_mix;
                        d_reg         <= (s_duck_amount > MIX_FULL) ? MIX_FULL : s_duck_amount;
                        last_trig_reg <= s_trigger;
                        if (s_trigger && !last_trig_reg) begin
                            frozen_pos_reg <= write_pos_reg;
                            phase_reg      <= '0;
                            count_reg      <= '0;
                        end
                        if (s_trigger) begin
                            op_a_reg  <= OPA_W'((s_wet_mix > MIX_FULL) ? MIX_FULL : s_wet_mix);
                            op_b_reg  <= OPB_W'((s_duck_amount > MIX_FULL) ?
                                                MIX_FULL : s_duck_amount);
                            state_reg <= ST_WRAP;
                        end else begin
                            write_pos_reg <= (write_pos_reg == LAST_ADDR) ?
                                             '0 : write_pos_reg + 1'b1;
                            op_a_reg  <= {{(OPA_W-SAMPLE_W-24){s_left_in[SAMPLE_W-1]}},
                                          s_left_in, 24'b0};
                            op_b_reg  <= OPB_W'(gain_eff);
                            state_reg <= ST_DRY1;
                        end
                    end
                end
                ST_DRY1: begin
                    op_a_reg  <= {{(OPA_W-SAMPLE_W-24){dr_reg[SAMPLE_W-1]}}, dr_reg, 24'b0};
                    op_b_reg  <= OPB_W'(gain_eff);
                    state_reg <= ST_DRY2;
                end
                ST_DRY2: begin
                    res_l_reg <= round_sat(prod_reg);
                    state_reg <= ST_DRY3;
                end
                ST_DRY3: begin
                    res_r_reg <= round_sat(prod_reg);
                    state_reg <= ST_DONE;
                end
                ST_WRAP: begin
                    if (phase_reg >= rate_reg) begin
                        phase_reg <= '0;
                        count_reg <= count_reg + 1'b1;
                    end
                    state_reg <= ST_LCG;
                end
                ST_LCG: begin
                    md_reg    <= prod_reg[OPB_W-2:0];
                    op_a_reg  <= OPA_W'(count_reg);
                    op_b_reg  <= OPB_W'(LCG_MUL_LO);
                    state_reg <= ST_LCG2;
                end
                ST_LCG2: begin
                    state_reg <= ST_DIR;
                end
                ST_DIR: begin
                    rev_reg     <= rev_next;
                    rd_base_reg <= XW'(frozen_pos_reg) + DEPTH_X - cap_reg + base_reg;
                    state_reg   <= ST_MOD;
                end
                ST_MOD: begin
                    if (div_rsp.done) begin
                        wp_reg    <= div_rsp.rem;
                        state_reg <= ST_ADDR;
                    end
                end
                ST_ADDR: begin
                    env_div_reg <= div_req.start;
                    e_reg       <= (phase_reg >= gate_reg) ? '0 : ENV_ONE;
                    state_reg   <= ST_ENV;
                end
                ST_ENV: begin
                    if (!env_div_reg || div_rsp.done) begin
                        e_reg     <= e_val;
                        op_a_reg  <= OPA_W'(md_reg);
                        op_b_reg  <= OPB_W'(e_val);
                        state_reg <= ST_X1;
                    end
                end
                ST_X1: begin
                    op_a_reg  <= OPA_W'(e_reg);
                    op_b_reg  <= OPB_W'(m_reg);
                    state_reg <= ST_X2;
                end
                ST_X2: begin
                    op_a_reg  <= OPA_W'(34'h1_0000_0000) - OPA_W'(prod_reg[32:0]);
                    op_b_reg  <= OPB_W'(MIX_FULL - m_reg);
                    state_reg <= ST_X3;
                end
                ST_X3: begin
                    cw_reg    <= prod_reg[24:0];
                    state_reg <= ST_X4;
                end
                ST_X4: begin
                    cd_reg    <= cd_next;
                    op_a_reg  <= OPA_W'(cd_next);
                    op_b_reg  <= OPB_W'(dl_reg);
                    state_reg <= ST_X5;
                end
                ST_X5: begin
                    op_a_reg  <= OPA_W'(cw_reg);
                    op_b_reg  <= OPB_W'(sl);
                    state_reg <= ST_X6;
                end
                ST_X6: begin
                    accl_reg  <= ACC_W'(prod_reg);
                    op_a_reg  <= OPA_W'(cd_reg);
                    op_b_reg  <= OPB_W'(dr_reg);
                    state_reg <= ST_X7;
                end
                ST_X7: begin
                    accl_reg  <= accl_reg + ACC_W'(prod_reg);
                    op_a_reg  <= OPA_W'(cw_reg);
                    op_b_reg  <= OPB_W'(sr);
                    state_reg <= ST_X8;
                end
                ST_X8: begin
                    accr_reg  <= ACC_W'(prod_reg);
                    op_a_reg  <= OPA_W'(accl_reg);
                    op_b_reg  <= OPB_W'(gain_eff);
                    state_reg <= ST_X9;
                end
                ST_X9: begin
                    op_a_reg  <= OPA_W'(accr_sum);
                    op_b_reg  <= OPB_W'(gain_eff);
                    state_reg <= ST_X10;
                end
                ST_X10: begin
                    res_l_reg <= round_sat(prod_reg);
                    state_reg <= ST_X11;
                end
                ST_X11: begin
                    res_r_reg <= round_sat(prod_reg);
                    phase_reg <= phase_reg + 1'b1;
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_left_reg  <= res_l_reg;
                        m_right_reg <= res_r_reg;
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_left_out  = m_left_reg;
    assign m_right_out = m_right_reg;

endmodule

@@ sv/sre_ram.sv @@
// generic single write port, single read port ram with registered read
// no dependencies
module sre_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/sre_div.sv @@
// restoring divider, one quotient bit per cycle, dividend left aligned
// depends on sre_pkg
module sre_div import sre_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DIV_NW-1:0] num_reg;
    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_DW-1:0] den_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DIV_DW:0] trial;
    logic [DIV_DW:0] diff;
    logic            ge;

    assign trial = {rem_reg, num_reg[DIV_NW-1]};
    assign ge    = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else if (req.start) begin
            num_reg  <= req.num;
            den_reg  <= req.den;
            rem_reg  <= '0;
            cnt_reg  <= req.steps;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end else if (busy_reg) begin
            num_reg <= {num_reg[DIV_NW-2:0], ge};
            rem_reg <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DIV_CW'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = num_reg;
    assign rsp.rem  = rem_reg;

endmodule
